// File: rtl/core/unique_id_allocator_macros.svh
// assertion macros shared by the identifier allocator rtl
`ifndef UNIQUE_ID_ALLOCATOR_MACROS_SVH
`define UNIQUE_ID_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// plain property, checked on every edge outside reset
`define UIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication, checked on every edge outside reset
`define UIA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define UIA_ASSERT(lbl, prop, msg)
`define UIA_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/uia_pkg.sv
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package uia_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ID_LIMIT_DEF      = 128;

  localparam int STATUS_W = 2;
  localparam int IDENT_W  = 7;
  localparam int SLOT_W   = 6;

  localparam logic FUNC_ALLOC  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ALLOC = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_HIT   = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_LOOK,
    S_WRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    init;
    logic    scan_run;
    logic    look_run;
    logic    commit;
    logic    res_ld;
    status_t res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic lookup;
    logic full;
    logic need_scan;
    logic query_ok;
    logic over;
    logic pass_end;
    logic hit;
  } dp_stat_t;

endpackage

// File: rtl/core/unique_id_allocator.sv
// top level: identifier allocator with cached safe window
// full, or a lookup id out of range, is answered from the decide state; an allocate
//   inside the safe window goes straight to write, otherwise it scans the table first
// lookup: reads the table until a hit, or a miss at the end of the filled entries
// scan restarts from slot zero at the bound; one word at a time, next start taken with done
// reset: synchronous, clears count, sets cursor and safe bound to ID_LIMIT; results cannot be stalled
`timescale 1ns / 1ps

module unique_id_allocator #(
  parameter int TABLE_ENTRIES = uia_pkg::TABLE_ENTRIES_DEF,
  parameter int ID_LIMIT      = uia_pkg::ID_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [uia_pkg::IDENT_W-1:0]  query_ident,
  output logic                         done,
  output logic [uia_pkg::STATUS_W-1:0] status,
  output logic [uia_pkg::IDENT_W-1:0]  ident,
  output logic [uia_pkg::SLOT_W-1:0]   slot
);

  import uia_pkg::*;

  // command and status bundles between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decides fast path, scan, lookup or full per request word
  uia_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: id ram, cursor/safe bound, scan engine, result word registers
  uia_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ID_LIMIT      (ID_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .query_ident (query_ident),
    .status      (status),
    .ident       (ident),
    .slot        (slot)
  );

endmodule

// File: rtl/core/uia_ram.sv
// generic simple dual port ram, registered read
`timescale 1ns / 1ps

module uia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/uia_datapath.sv
// identifier table, cursor, safe bound, scan engine and result registers
`timescale 1ns / 1ps
`include "unique_id_allocator_macros.svh"

module uia_datapath #(
  parameter int TABLE_ENTRIES = uia_pkg::TABLE_ENTRIES_DEF,
  parameter int ID_LIMIT      = uia_pkg::ID_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  uia_pkg::dp_cmd_t             cmd,
  output uia_pkg::dp_stat_t            stat,
  input  logic                         func,
  input  logic [uia_pkg::IDENT_W-1:0]  query_ident,
  output logic [uia_pkg::STATUS_W-1:0] status,
  output logic [uia_pkg::IDENT_W-1:0]  ident,
  output logic [uia_pkg::SLOT_W-1:0]   slot
);

  import uia_pkg::*;

  localparam int AW       = $clog2(TABLE_ENTRIES);
  localparam int CNTW     = $clog2(TABLE_ENTRIES + 1);
  localparam int IDW      = $clog2(ID_LIMIT);
  localparam int CW       = $clog2(ID_LIMIT + 2);
  localparam int PASS_MAX = 2 * ID_LIMIT + 2;
  localparam int PW       = $clog2(PASS_MAX + 1);

  // architectural state
  logic [CNTW-1:0]    entry_count;
  logic [CW-1:0]      cursor;
  logic [CW-1:0]      safe_bound;

  // request and scan working registers
  logic               func_q;
  logic [IDENT_W-1:0] query_q;
  logic [CW-1:0]      cand;
  logic [CW-1:0]      safe;
  logic [PW-1:0]      passes;
  logic [CNTW-1:0]    rd_idx;
  logic               pend;
  logic [AW-1:0]      pend_idx;

  logic [IDW-1:0]     rd_data;
  logic [CW-1:0]      rd_val;
  logic [CW-1:0]      cand0;
  logic [CW-1:0]      cand_inc;
  logic               rd_en;
  logic               match;
  logic               step_again;

  uia_ram #(
    .WIDTH (IDW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ident_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (entry_count[AW-1:0]),
    .wdata (IDW'(cand)),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_data)
  );

  assign rd_val     = CW'(rd_data);
  assign cand0      = cursor + CW'(1);
  assign cand_inc   = cand + CW'(1);
  assign rd_en      = rd_idx < entry_count;
  assign match      = pend && (rd_val == cand);
  assign step_again = match && (cand_inc >= safe);

  assign stat.lookup    = (func_q == FUNC_LOOKUP);
  assign stat.full      = (int'(entry_count) >= TABLE_ENTRIES) ||
                          (int'(entry_count) + 1 >= ID_LIMIT);
  assign stat.need_scan = (int'(cand0) >= ID_LIMIT) || (cand0 >= safe_bound);
  assign stat.query_ok  = (query_q != '0) && (int'(query_q) < ID_LIMIT);
  assign stat.over      = step_again && (int'(passes) >= PASS_MAX);
  assign stat.pass_end  = !pend && !rd_en;
  assign stat.hit       = pend && (32'(rd_data) == 32'(query_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      cursor      <= CW'(ID_LIMIT);
      safe_bound  <= CW'(ID_LIMIT);
    end else if (cmd.commit) begin
      entry_count <= entry_count + CNTW'(1);
      cursor      <= cand;
      safe_bound  <= safe;
    end
  end

  // request capture and scan engine: one table entry compared per cycle behind the registered read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q  <= func;
      query_q <= query_ident;
    end
    if (cmd.init) begin
      cand   <= (int'(cand0) >= ID_LIMIT) ? CW'(1) : cand0;
      safe   <= stat.need_scan ? CW'(ID_LIMIT) : safe_bound;
      passes <= '0;
      rd_idx <= '0;
      pend   <= 1'b0;
    end else if (cmd.scan_run || cmd.look_run) begin
      if (cmd.scan_run && step_again) begin
        // candidate ran into the bound: restart the pass from slot zero
        cand   <= (int'(cand_inc) >= ID_LIMIT) ? CW'(1) : cand_inc;
        safe   <= CW'(ID_LIMIT);
        passes <= passes + PW'(1);
        rd_idx <= '0;
        pend   <= 1'b0;
      end else begin
        if (cmd.scan_run && match) begin
          cand <= cand_inc;
        end else if (cmd.scan_run && pend && (rd_val > cand) && (safe > rd_val)) begin
          safe <= rd_val;
        end
        rd_idx   <= rd_en ? rd_idx + CNTW'(1) : rd_idx;
        pend     <= rd_en;
        pend_idx <= rd_idx[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      status <= cmd.res_code;
      case (cmd.res_code)
        STAT_ALLOC: begin
          ident <= IDENT_W'(cand);
          slot  <= SLOT_W'(entry_count);
        end
        STAT_HIT: begin
          ident <= query_q;
          slot  <= SLOT_W'(pend_idx);
        end
        STAT_MISS: begin
          ident <= query_q;
          slot  <= '0;
        end
        default: begin
          ident <= '0;
          slot  <= '0;
        end
      endcase
    end
  end

  `UIA_ASSERT(a_count_bound, int'(entry_count) <= TABLE_ENTRIES, "entry count past table size")
  `UIA_ASSERT(a_safe_above_cursor, safe_bound >= cursor, "safe bound fell below cursor")
  `UIA_ASSERT_IMPL(a_commit_not_full, cmd.commit, !stat.full, "commit into a full table")

endmodule

// File: rtl/core/uia_ctrl.sv
// request sequencer for the identifier allocator
`timescale 1ns / 1ps
`include "unique_id_allocator_macros.svh"

module uia_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  uia_pkg::dp_stat_t stat,
  output uia_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);

  import uia_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = STAT_ALLOC;
    busy         = 1'b1;
    done         = 1'b0;
    case (state)
      S_IDLE, S_RESP: begin
        busy = 1'b0;
        done = (state == S_RESP);
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DECIDE: begin
        cmd.init = 1'b1;
        if (stat.lookup) begin
          if (stat.query_ok) begin
            state_next = S_LOOK;
          end else begin
            cmd.res_ld   = 1'b1;
            cmd.res_code = STAT_MISS;
            state_next   = S_RESP;
          end
        end else if (stat.full) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = STAT_FULL;
          state_next   = S_RESP;
        end else if (stat.need_scan) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.over) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = STAT_FULL;
          state_next   = S_RESP;
        end else if (stat.pass_end) begin
          state_next = S_WRITE;
        end
      end
      S_LOOK: begin
        cmd.look_run = 1'b1;
        if (stat.hit) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = STAT_HIT;
          state_next   = S_RESP;
        end else if (stat.pass_end) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = STAT_MISS;
          state_next   = S_RESP;
        end
      end
      S_WRITE: begin
        cmd.commit   = 1'b1;
        cmd.res_ld   = 1'b1;
        cmd.res_code = STAT_ALLOC;
        state_next   = S_RESP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `UIA_ASSERT(a_done_single, done |=> !done, "result strobe held two cycles")
  `UIA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request taken but not busy")
  `UIA_ASSERT(a_done_after_work, done |-> $past(busy), "result without work")

endmodule

// File: tb/sv/unique_id_allocator_tb.sv
// self-checking testbench for the unique identifier allocator
`timescale 1ns / 1ps

module unique_id_allocator_tb;
  import uia_pkg::*;

  localparam int NSLOT       = TABLE_ENTRIES_DEF;
  localparam int IDLIM       = ID_LIMIT_DEF;
  localparam int RANDOM_REQS = 1500;
  // hang guard bound for the whole run, idle gaps between request words included
  localparam int CYCLE_LIMIT = 600000;
  // idle wait after the last answer, before declaring the block quiet
  localparam int DRAIN_WAIT  = 2 * NSLOT + 8;

  // one expected answer from the allocator
  typedef struct {
    status_t              st;
    logic [IDENT_W-1:0]   id;
    logic [SLOT_W-1:0]    sl;
  } answer_t;

  // mirror of the identifier table plus the answers still owed by the block
  class ident_table_model;
    logic [IDENT_W-1:0] id_of_slot[NSLOT];
    bit                 slot_used[NSLOT];
    int                 entries;
    int                 cursor;
    int                 safe_bound;
    answer_t            awaited_answers[$];
    int                 mismatches;
    int                 grants, fulls, hits, misses;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        id_of_slot[i] = '0;
        slot_used[i]  = 1'b0;
      end
      entries    = 0;
      cursor     = IDLIM;
      safe_bound = IDLIM;
      mismatches = 0;
      grants     = 0;
      fulls      = 0;
      hits       = 0;
      misses     = 0;
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction

    task flag_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // next free identifier after the cursor, with the safe-window shortcut
    function answer_t grant_ident();
      answer_t w;
      int      free_slot;
      int      cand;
      int      bound;
      int      passes;
      bit      rescan;
      w.st = STAT_FULL;
      w.id = '0;
      w.sl = '0;
      if (entries >= NSLOT || entries + 1 >= IDLIM) return w;
      free_slot = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!slot_used[i]) begin
          free_slot = i;
          break;
        end
      end
      if (free_slot < 0) return w;
      cand   = cursor + 1;
      bound  = safe_bound;
      rescan = 1'b0;
      if (cand >= IDLIM) begin
        cand   = 1;
        rescan = 1'b1;
      end else if (cand >= bound) begin
        rescan = 1'b1;
      end
      if (rescan) begin
        bound  = IDLIM;
        passes = 0;
        do begin
          rescan = 1'b0;
          for (int i = 0; i < NSLOT; i++) begin
            if (!slot_used[i]) continue;
            if (id_of_slot[i] == cand) begin
              cand++;
              if (cand >= bound) begin
                if (cand >= IDLIM) cand = 1;
                bound  = IDLIM;
                rescan = 1'b1;
                break;
              end
            end else if (id_of_slot[i] > cand && bound > id_of_slot[i]) begin
              bound = id_of_slot[i];
            end
          end
          if (rescan) begin
            passes++;
            if (passes > 2 * IDLIM + 2) return w;
          end
        end while (rescan);
      end
      cursor                = cand;
      safe_bound            = bound;
      id_of_slot[free_slot] = IDENT_W'(cand);
      slot_used[free_slot]  = 1'b1;
      entries++;
      w.st = STAT_ALLOC;
      w.id = IDENT_W'(cand);
      w.sl = SLOT_W'(free_slot);
      return w;
    endfunction

    function answer_t find_ident(logic [IDENT_W-1:0] q);
      answer_t w;
      w.st = STAT_MISS;
      w.id = q;
      w.sl = '0;
      if (q != 0 && q < IDLIM) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_used[i] && id_of_slot[i] == q) begin
            w.st = STAT_HIT;
            w.sl = SLOT_W'(i);
            break;
          end
        end
      end
      return w;
    endfunction

    function void log_request(logic f, logic [IDENT_W-1:0] q);
      if (f == FUNC_ALLOC) awaited_answers.push_back(grant_ident());
      else awaited_answers.push_back(find_ident(q));
    endfunction

    task check_answer(logic [STATUS_W-1:0] st, logic [IDENT_W-1:0] id,
                      logic [SLOT_W-1:0] sl);
      answer_t w;
      if (awaited_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected word status=%0d ident=%0d slot=%0d",
                                st, id, sl));
        return;
      end
      w = awaited_answers.pop_front();
      case (w.st)
        STAT_ALLOC: grants++;
        STAT_FULL:  fulls++;
        STAT_HIT:   hits++;
        default:    misses++;
      endcase
      if (st !== w.st)
        flag_mismatch($sformatf("status %0d, expected %0d", st, w.st));
      if (id !== w.id)
        flag_mismatch($sformatf("ident %0d, expected %0d (status %0d)", id, w.id, w.st));
      if (sl !== w.sl)
        flag_mismatch($sformatf("slot %0d, expected %0d (status %0d)", sl, w.sl, w.st));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic                func;
  logic [IDENT_W-1:0]  query_ident;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [IDENT_W-1:0]  ident;
  logic [SLOT_W-1:0]   slot;

  ident_table_model tracker = new();
  bit               allow_idle;
  int               cycles;

  unique_id_allocator DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .query_ident (query_ident),
    .done        (done),
    .status      (status),
    .ident       (ident),
    .slot        (slot)
  );

  always #6 clk = ~clk;

  // results cannot be held off, so every done strobe is checked right away;
  // values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst && done) tracker.check_answer(status, ident, slot);
  end

  // hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles, tracker.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one request word and hold it until the block takes it; start stays
  // high straight into the next word when no idle gap is drawn
  task automatic send_word(logic f, logic [IDENT_W-1:0] q);
    int gap;
    if (allow_idle && $urandom_range(99) < 32) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    func        <= f;
    query_ident <= q;
    do @(posedge clk); while (busy);
    tracker.log_request(f, q);
  endtask

  task automatic lookup_word(logic [IDENT_W-1:0] q);
    send_word(FUNC_LOOKUP, q);
  endtask

  task automatic alloc_word();
    // query field is don't-care on allocate, so keep it moving
    send_word(FUNC_ALLOC, IDENT_W'($urandom));
  endtask

  // short directed opening: empty-table lookups, the first grant that wraps the
  // cursor and scans, back-to-back grants inside the safe window, hits and misses
  task automatic directed_words();
    lookup_word('0);                // id zero never hits
    lookup_word(7'h7f);             // top of the field
    lookup_word(7'd1);              // nothing granted yet
    alloc_word();                   // cursor wraps to 1 with a table scan
    alloc_word();
    alloc_word();
    lookup_word(7'd1);
    lookup_word(7'd2);
    lookup_word(7'd3);
    lookup_word(7'd4);              // one past the last grant
    lookup_word(7'h55);
    lookup_word(7'h2a);
    alloc_word();
    alloc_word();
    lookup_word(7'd5);
    lookup_word(7'd64);
    lookup_word(7'h40);
    lookup_word('0);
    alloc_word();
    lookup_word(7'd6);
  endtask

  // random mix: rare grants so the table fills part way through the run and
  // full answers get exercised afterward; lookups lean toward the granted range
  task automatic random_words();
    int r;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      allow_idle = !(n >= 500 && n < 800);  // one long stretch at full rate
      r = $urandom_range(99);
      if (r < 7) begin
        alloc_word();
      end else if (r < 55) begin
        lookup_word(IDENT_W'($urandom_range(1, NSLOT + 6)));
      end else if (r < 95) begin
        lookup_word(IDENT_W'($urandom_range(0, IDLIM - 1)));
      end else if (r < 97) begin
        lookup_word('0);
      end else begin
        lookup_word(IDENT_W'(IDLIM - 1));
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    func        = FUNC_ALLOC;
    query_ident = '0;
    cycles      = 0;
    allow_idle  = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_words();
    random_words();

    // top off the table, knock on it once full, then sweep every identifier
    // so each slot shows up in a hit
    while (tracker.entries < NSLOT) alloc_word();
    repeat (4) alloc_word();
    for (int q = 0; q < IDLIM; q++) lookup_word(IDENT_W'(q));

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (tracker.pending() != 0)
      tracker.flag_mismatch($sformatf("%0d words never arrived", tracker.pending()));
    $display("run covered %0d grants, %0d full answers, %0d lookup hits, %0d lookup misses",
             tracker.grants, tracker.fulls, tracker.hits, tracker.misses);
    $display("table ended with %0d of %0d slots in use, %0d mismatches",
             tracker.entries, NSLOT, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
